FILE: rtl/pbaz_pkg.sv
package pbaz_pkg;

	localparam int PAGE_BYTES = 256;
	localparam int RAM_PAGES = 8;
	localparam int ALT_PAGES = 2;
	localparam logic [7:0] IO_PAGE = 8'hC0;

	localparam int MAIN_DEPTH = RAM_PAGES * PAGE_BYTES;
	localparam int ALT_DEPTH = ALT_PAGES * PAGE_BYTES;
	localparam int MAIN_AW = $clog2(MAIN_DEPTH);
	localparam int ALT_AW = $clog2(ALT_DEPTH);

	localparam logic [7:0] SW_MAIN_BANK = 8'h08;
	localparam logic [7:0] SW_ALT_BANK = 8'h09;
	localparam logic [7:0] SW_READ_BANK = 8'h16;
	localparam logic [7:0] SW_CHAR_OUT = 8'h2A;
	localparam logic [7:0] BANK_FLAG = 8'h80;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		SEL_MAIN,
		SEL_ALT,
		SEL_IMM
	} sel_t;

	typedef struct packed {
		sel_t sel;
		logic [7:0] imm;
		logic chr_valid;
		logic [7:0] chr;
	} s1_ctrl_t;

endpackage

FILE: rtl/pbaz_ram.sv
module pbaz_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic en,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: rtl/paged_bus_with_alt_zero_page.sv
// Decodes one 8-bit CPU bus transfer per clock: low pages go to main RAM, pages 0-1 go to an
// alternate bank while it is selected, and the I/O page holds the bank soft switches, the
// bank status read and the character output switch. After reset the block clears every
// address of both RAMs to zero and holds in_ready low meanwhile. After that it accepts
// one transfer every cycle while the output is not stalled; a result passes through the
// registered read of the RAM and then the output register, and a stalled output lets one
// more transfer in before in_ready drops.
module paged_bus_with_alt_zero_page (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic operation,
	input logic [15:0] bus_address,
	input logic [7:0] write_data,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] read_data,
	output logic char_valid,
	output logic [7:0] char_out
);

	logic clearing_q;
	logic [pbaz_pkg::MAIN_AW-1:0] clr_q;
	logic alt_q;
	logic valid_s1;
	pbaz_pkg::s1_ctrl_t ctrl_s1;
	pbaz_pkg::s1_ctrl_t ctrl_d;
	logic [7:0] read_data_q;
	logic char_valid_q;
	logic [7:0] char_out_q;
	logic out_valid_q;

	logic accept;
	logic s1_adv;
	logic [7:0] page;
	logic [7:0] low;
	logic is_wr;
	logic is_ram;
	logic use_alt;
	logic is_io;
	logic main_en;
	logic main_we;
	logic [pbaz_pkg::MAIN_AW-1:0] main_addr;
	logic [7:0] main_wdata;
	logic [7:0] main_rdata;
	logic alt_en;
	logic alt_we;
	logic [pbaz_pkg::ALT_AW-1:0] alt_addr;
	logic [7:0] alt_wdata;
	logic [7:0] alt_rdata;
	logic [7:0] result;

	assign s1_adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clearing_q && (!valid_s1 || s1_adv);
	assign accept = in_valid && in_ready;

	assign page = bus_address[15:8];
	assign low = bus_address[7:0];
	assign is_wr = (operation == pbaz_pkg::OP_WRITE);
	assign is_ram = ({1'b0, page} < 9'(pbaz_pkg::RAM_PAGES));
	assign use_alt = alt_q && ({1'b0, page} < 9'(pbaz_pkg::ALT_PAGES));
	assign is_io = !is_ram && (page == pbaz_pkg::IO_PAGE);

	always_comb begin
		main_en = 1'b0;
		main_we = 1'b0;
		main_addr = bus_address[pbaz_pkg::MAIN_AW-1:0];
		main_wdata = write_data;
		alt_en = 1'b0;
		alt_we = 1'b0;
		alt_addr = bus_address[pbaz_pkg::ALT_AW-1:0];
		alt_wdata = write_data;
		if (clearing_q) begin
			main_en = 1'b1;
			main_we = 1'b1;
			main_addr = clr_q;
			main_wdata = 8'h00;
			alt_en = ({1'b0, clr_q} < (pbaz_pkg::MAIN_AW+1)'(pbaz_pkg::ALT_DEPTH));
			alt_we = 1'b1;
			alt_addr = clr_q[pbaz_pkg::ALT_AW-1:0];
			alt_wdata = 8'h00;
		end else if (accept && is_ram) begin
			main_en = !use_alt;
			main_we = is_wr;
			alt_en = use_alt;
			alt_we = is_wr;
		end
	end

	always_comb begin
		ctrl_d.sel = pbaz_pkg::SEL_IMM;
		ctrl_d.imm = 8'h00;
		ctrl_d.chr_valid = 1'b0;
		ctrl_d.chr = 8'h00;
		if (is_ram) begin
			if (is_wr) begin
				ctrl_d.imm = write_data;
			end else if (use_alt) begin
				ctrl_d.sel = pbaz_pkg::SEL_ALT;
			end else begin
				ctrl_d.sel = pbaz_pkg::SEL_MAIN;
			end
		end else if (is_io) begin
			ctrl_d.imm = write_data;
			if (is_wr) begin
				if (low == pbaz_pkg::SW_CHAR_OUT && write_data != 8'h00) begin
					ctrl_d.chr_valid = 1'b1;
					ctrl_d.chr = write_data;
				end
			end else if (low == pbaz_pkg::SW_READ_BANK) begin
				ctrl_d.imm = alt_q ? pbaz_pkg::BANK_FLAG : 8'h00;
			end
		end
	end

	pbaz_ram #(
		.DEPTH(pbaz_pkg::MAIN_DEPTH),
		.WIDTH(8)
	) u_main_ram (
		.clk(clk),
		.en(main_en),
		.we(main_we),
		.addr(main_addr),
		.wdata(main_wdata),
		.rdata(main_rdata)
	);

	pbaz_ram #(
		.DEPTH(pbaz_pkg::ALT_DEPTH),
		.WIDTH(8)
	) u_alt_ram (
		.clk(clk),
		.en(alt_en),
		.we(alt_we),
		.addr(alt_addr),
		.wdata(alt_wdata),
		.rdata(alt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == pbaz_pkg::MAIN_AW'(pbaz_pkg::MAIN_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= 1'b0;
		end else if (accept && is_io && is_wr) begin
			if (low == pbaz_pkg::SW_MAIN_BANK) begin
				alt_q <= 1'b0;
			end else if (low == pbaz_pkg::SW_ALT_BANK) begin
				alt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_comb begin
		case (ctrl_s1.sel)
			pbaz_pkg::SEL_MAIN: result = main_rdata;
			pbaz_pkg::SEL_ALT: result = alt_rdata;
			default: result = ctrl_s1.imm;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data_q <= result;
			char_valid_q <= ctrl_s1.chr_valid;
			char_out_q <= ctrl_s1.chr;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign char_valid = char_valid_q;
	assign char_out = char_out_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !accept)
		else $error("transfer accepted while RAMs are being cleared");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_q) == pbaz_pkg::MAIN_AW'(pbaz_pkg::MAIN_DEPTH - 1))
		else $error("clearing pass ended early");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> valid_s1 && $stable(ctrl_s1))
		else $error("stalled stage lost its transfer");

	a_alt_set: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_io && is_wr && low == pbaz_pkg::SW_ALT_BANK) |=> alt_q)
		else $error("alternate bank switch not taken");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && char_valid) |-> char_out != 8'h00)
		else $error("character output with a zero byte");

endmodule
